// ----- rtl/core/rc4kx_pkg.sv -----
package rc4kx_pkg;

  localparam int unsigned KEY_W  = 64;
  localparam int unsigned EKEY_W = 160;

  // key expansion constants, subtracted ones stored negated
  localparam logic [31:0] K_T_NEG = ~32'd1615554381 + 32'd1;
  localparam logic [31:0] K_P     = 32'd1722862861;
  localparam logic [31:0] K_MASKA = 32'h22222222;
  localparam logic [31:0] K_MASKB = 32'h7BF36AE2;
  localparam logic [31:0] K_R_NEG = ~32'd214083945 + 32'd1;
  localparam logic [31:0] K_S     = 32'h59D148C0;
  localparam logic [31:0] K_V_NEG = ~32'd696916869 + 32'd1;
  localparam logic [31:0] K_W_NEG = ~32'd1269579175 + 32'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXP,
    ST_INIT,
    ST_KS_RI,
    ST_KS_RJ,
    ST_KS_WI,
    ST_KS_WJ,
    ST_GEN_RI,
    ST_GEN_RJ,
    ST_GEN_WI,
    ST_GEN_WJ,
    ST_GEN_RK,
    ST_GEN_OUT
  } rc4kx_state_t;

  // one adder operation per step of the key expansion
  typedef enum logic [4:0] {
    EX_T   = 5'd0,
    EX_P0  = 5'd1,
    EX_P   = 5'd2,
    EX_R0  = 5'd3,
    EX_R1  = 5'd4,
    EX_R   = 5'd5,
    EX_V0  = 5'd6,
    EX_V1  = 5'd7,
    EX_V   = 5'd8,
    EX_W0A = 5'd9,
    EX_W0B = 5'd10,
    EX_W0C = 5'd11,
    EX_W0  = 5'd12,
    EX_W1  = 5'd13,
    EX_W2  = 5'd14,
    EX_W3  = 5'd15,
    EX_W4  = 5'd16
  } exp_step_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

endpackage

// ----- rtl/core/rc4kx_in_if.sv -----
interface rc4kx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       new_message;

  modport source (output valid, output data_byte, output new_message, input ready);
  modport sink (input valid, input data_byte, input new_message, output ready);
endinterface

// ----- rtl/core/rc4kx_out_if.sv -----
interface rc4kx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink (input valid, input out_byte, output ready);
endinterface

// ----- rtl/core/rc4_with_key_expansion_core.sv -----
// RC4 stream cipher with a fixed 64-bit to 160-bit key expansion.
// in_ch carries one payload byte per transfer plus a new_message flag; out_ch
// returns that byte XORed with the next keystream byte, one result per input.
// cfg_we/cfg_wdata load the 64-bit key; a new key is used from the next input
// that has new_message set.
// The block takes one input at a time and is not ready while it works: a
// plain byte takes five accesses of the single-port 256x8 permutation RAM,
// then waits for the output register to be free before ready rises again.
// A byte with new_message first goes through key expansion (one shared
// 32-bit adder, one add per cycle), the fill of all 256 permutation entries
// and the key schedule (four RAM accesses per entry) before the plain-byte steps.
// Reset (rst_n low, synchronous) clears the key to zero, both indices and
// the handshake state; the permutation is undefined until the first
// new_message input. The result sits in an output register; if the receiver
// stalls, the next byte is taken but held at its last step until the
// register frees up.
module rc4_with_key_expansion_core
  import rc4kx_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  rc4kx_in_if.sink           in_ch,
  rc4kx_out_if.source        out_ch,
  input  logic               cfg_we,
  input  logic [KEY_W-1:0]   cfg_wdata
);

  rc4kx_state_t state_r, state_nxt;
  exp_step_t    step_r;

  logic [KEY_W-1:0]  key_word_r;
  logic [EKEY_W-1:0] ekey_r;
  logic [31:0]       t_r, p_r, r_r, v_r, x_r;
  logic [7:0]        cnt_r, j_r, a_r, b_r, si_r, sj_r, data_r;
  logic [7:0]        out_byte_r;
  logic              out_valid_r;

  logic [7:0] perm_mem [256];
  logic [7:0] rd_r;
  logic       mem_we, mem_re;
  logic [7:0] mem_addr, mem_wdata;

  logic [31:0] lo, hi, q, u, s, f, g, opa, opb, sum;
  logic        out_free, in_xfer;

  assign lo       = key_word_r[31:0];
  assign hi       = key_word_r[63:32];
  assign q        = rotl32(t_r, 30);
  assign u        = rotl32(p_r, 30);
  assign s        = (p_r & (q ^ K_S)) ^ K_S;
  assign f        = (~(t_r & K_MASKA)) & K_MASKB;
  assign g        = q ^ (r_r & (u ^ q));
  assign sum      = opa + opb;
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_xfer  = in_ch.valid && in_ch.ready;

  // shared adder operand select
  always_comb begin
    opa = x_r;
    opb = '0;
    unique case (step_r)
      EX_T:    begin opa = lo;                opb = K_T_NEG;            end
      EX_P0:   begin opa = rotl32(t_r, 5);    opb = hi;                 end
      EX_P:    begin opa = x_r;               opb = K_P;                end
      EX_R0:   begin opa = f;                 opb = K_R_NEG;            end
      EX_R1:   begin opa = x_r;               opb = lo;                 end
      EX_R:    begin opa = x_r;               opb = rotl32(p_r, 5);     end
      EX_V0:   begin opa = s;                 opb = K_V_NEG;            end
      EX_V1:   begin opa = x_r;               opb = hi;                 end
      EX_V:    begin opa = x_r;               opb = rotl32(r_r, 5);     end
      EX_W0A:  begin opa = lo;                opb = rotl32(v_r, 5);     end
      EX_W0B:  begin opa = x_r;               opb = lo;                 end
      EX_W0C:  begin opa = x_r;               opb = g;                  end
      EX_W0:   begin opa = x_r;               opb = K_W_NEG;            end
      EX_W1:   begin opa = hi;                opb = v_r;                end
      EX_W2:   begin opa = lo;                opb = rotl32(r_r, 30);    end
      EX_W3:   begin opa = hi;                opb = u;                  end
      EX_W4:   begin opa = lo;                opb = q;                  end
      default: begin opa = x_r;               opb = '0;                 end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = in_ch.new_message ? ST_EXP : ST_GEN_RI;
        end
      end
      ST_EXP:     if (step_r == EX_W4) state_nxt = ST_INIT;
      ST_INIT:    if (cnt_r == 8'hFF) state_nxt = ST_KS_RI;
      ST_KS_RI:   state_nxt = ST_KS_RJ;
      ST_KS_RJ:   state_nxt = ST_KS_WI;
      ST_KS_WI:   state_nxt = ST_KS_WJ;
      ST_KS_WJ:   state_nxt = (cnt_r == 8'hFF) ? ST_GEN_RI : ST_KS_RI;
      ST_GEN_RI:  state_nxt = ST_GEN_RJ;
      ST_GEN_RJ:  state_nxt = ST_GEN_WI;
      ST_GEN_WI:  state_nxt = ST_GEN_WJ;
      ST_GEN_WJ:  state_nxt = ST_GEN_RK;
      ST_GEN_RK:  state_nxt = ST_GEN_OUT;
      ST_GEN_OUT: if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // memory control and handshake outputs
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = cnt_r;
    mem_wdata = rd_r;
    unique case (state_r)
      ST_INIT:    begin mem_we = 1'b1; mem_addr = cnt_r; mem_wdata = cnt_r; end
      ST_KS_RI:   begin mem_re = 1'b1; mem_addr = cnt_r; end
      ST_KS_RJ:   begin mem_re = 1'b1; mem_addr = j_r + rd_r + ekey_r[7:0]; end
      ST_KS_WI:   begin mem_we = 1'b1; mem_addr = cnt_r; mem_wdata = rd_r; end
      ST_KS_WJ:   begin mem_we = 1'b1; mem_addr = j_r; mem_wdata = si_r; end
      ST_GEN_RI:  begin mem_re = 1'b1; mem_addr = a_r + 8'd1; end
      ST_GEN_RJ:  begin mem_re = 1'b1; mem_addr = b_r + rd_r; end
      ST_GEN_WI:  begin mem_we = 1'b1; mem_addr = a_r; mem_wdata = rd_r; end
      ST_GEN_WJ:  begin mem_we = 1'b1; mem_addr = b_r; mem_wdata = si_r; end
      ST_GEN_RK:  begin mem_re = 1'b1; mem_addr = si_r + sj_r; end
      default:    begin mem_we = 1'b0; mem_re = 1'b0; end
    endcase
  end

  assign in_ch.ready     = (state_r == ST_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;

  // permutation ram
  always_ff @(posedge clk) begin
    if (mem_we) begin
      perm_mem[mem_addr] <= mem_wdata;
    end else if (mem_re) begin
      rd_r <= perm_mem[mem_addr];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= EX_T;
      key_word_r  <= '0;
      cnt_r       <= '0;
      a_r         <= '0;
      b_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        key_word_r <= cfg_wdata;
      end
      if (in_xfer && in_ch.new_message) begin
        step_r <= EX_T;
        cnt_r  <= '0;
        a_r    <= '0;
        b_r    <= '0;
      end
      if (state_r == ST_EXP) begin
        step_r <= exp_step_t'(step_r + 5'd1);
      end
      if (state_r == ST_INIT || state_r == ST_KS_WJ) begin
        cnt_r <= cnt_r + 8'd1;
      end
      if (state_r == ST_GEN_RI) begin
        a_r <= a_r + 8'd1;
      end
      if (state_r == ST_GEN_RJ) begin
        b_r <= b_r + rd_r;
      end
      if (state_r == ST_GEN_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      data_r <= in_ch.data_byte;
      j_r    <= '0;
    end
    if (state_r == ST_EXP) begin
      x_r <= sum;
      unique case (step_r)
        EX_T:    t_r <= sum;
        EX_P:    p_r <= sum;
        EX_R:    r_r <= sum;
        EX_V:    v_r <= sum;
        EX_W0:   ekey_r[31:0]    <= sum;
        EX_W1:   ekey_r[63:32]   <= sum;
        EX_W2:   ekey_r[95:64]   <= sum;
        EX_W3:   ekey_r[127:96]  <= sum;
        EX_W4:   ekey_r[159:128] <= sum;
        default: ;
      endcase
    end
    if (state_r == ST_KS_RJ) begin
      si_r   <= rd_r;
      j_r    <= j_r + rd_r + ekey_r[7:0];
      ekey_r <= {ekey_r[7:0], ekey_r[EKEY_W-1:8]};
    end
    if (state_r == ST_GEN_RJ) begin
      si_r <= rd_r;
    end
    if (state_r == ST_GEN_WI) begin
      sj_r <= rd_r;
    end
    if (state_r == ST_GEN_OUT && out_free) begin
      out_byte_r <= data_r ^ rd_r;
    end
  end

endmodule

// ----- tb/tb.sv -----
module tb
  import rc4kx_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BYTE_TARGET = 550;
  localparam int unsigned LONG_MSG_LEN = 300;
  localparam int unsigned EKEY_BYTES = 20;

  localparam logic [31:0] MIX_T   = 32'd1615554381;
  localparam logic [31:0] MIX_P   = 32'd1722862861;
  localparam logic [31:0] MIX_MA  = 32'h22222222;
  localparam logic [31:0] MIX_MB  = 32'h7BF36AE2;
  localparam logic [31:0] MIX_R   = 32'd214083945;
  localparam logic [31:0] MIX_S   = 32'h59D148C0;
  localparam logic [31:0] MIX_V   = 32'd696916869;
  localparam logic [31:0] MIX_W   = 32'd1269579175;

  typedef struct packed {
    logic        load;
    logic [63:0] key;
    logic [7:0]  data;
    logic        start;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [KEY_W-1:0] cfg_wdata;

  rc4kx_in_if  in_ch ();
  rc4kx_out_if out_ch ();

  rc4_with_key_expansion_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  logic [63:0] key_shadow;
  logic [7:0]  perm_shadow [256];
  logic [7:0]  ekey_shadow [EKEY_BYTES];
  logic [7:0]  idx_i;
  logic [7:0]  idx_j;

  logic [7:0]  expected_bytes [$];
  logic        no_idle;
  int unsigned fail_count;
  int unsigned bytes_sent;
  int unsigned results_checked;
  int unsigned msg_count;
  int unsigned key_loads;

  stim_row_t directed_rows [20];

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [31:0] rot_left(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic stretch_key();
    logic [31:0] lo, hi, t, p, q, r, s, u, v;
    logic [31:0] w [5];
    lo = key_shadow[31:0];
    hi = key_shadow[63:32];
    t = lo - MIX_T;
    p = rot_left(t, 5) + hi + MIX_P;
    q = rot_left(t, 30);
    r = ((~(t & MIX_MA)) & MIX_MB) - MIX_R + lo + rot_left(p, 5);
    s = (p & (q ^ MIX_S)) ^ MIX_S;
    u = rot_left(p, 30);
    v = s - MIX_V + hi + rot_left(r, 5);
    w[0] = lo + rot_left(v, 5) + lo + (q ^ (r & (u ^ q))) - MIX_W;
    w[1] = hi + v;
    w[2] = lo + rot_left(r, 30);
    w[3] = hi + u;
    w[4] = lo + q;
    for (int k = 0; k < 5; k++) begin
      for (int b = 0; b < 4; b++) begin
        ekey_shadow[4*k+b] = w[k][8*b +: 8];
      end
    end
  endtask

  task automatic schedule_perm();
    logic [7:0] j, tmp;
    j = 8'd0;
    for (int i = 0; i < 256; i++) perm_shadow[i] = 8'(i);
    for (int i = 0; i < 256; i++) begin
      j = j + perm_shadow[i] + ekey_shadow[i % EKEY_BYTES];
      tmp = perm_shadow[i];
      perm_shadow[i] = perm_shadow[j];
      perm_shadow[j] = tmp;
    end
    idx_i = 8'd0;
    idx_j = 8'd0;
  endtask

  task automatic predict_cipher_byte(input logic [7:0] d, input logic start);
    logic [7:0] tmp, sum;
    if (start) begin
      stretch_key();
      schedule_perm();
    end
    idx_i = idx_i + 8'd1;
    idx_j = idx_j + perm_shadow[idx_i];
    tmp = perm_shadow[idx_i];
    perm_shadow[idx_i] = perm_shadow[idx_j];
    perm_shadow[idx_j] = tmp;
    sum = perm_shadow[idx_i] + perm_shadow[idx_j];
    expected_bytes = {expected_bytes, d ^ perm_shadow[sum]};
  endtask

  // entered and left at a falling edge
  task automatic send_byte(input logic [7:0] d, input logic start);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.data_byte = d;
    in_ch.new_message = start;
    do @(posedge clk); while (!in_ch.ready);
    predict_cipher_byte(d, start);
    bytes_sent++;
    if (start) msg_count++;
    @(negedge clk);
  endtask

  task automatic load_key(input logic [63:0] k);
    in_ch.valid = 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = k;
    @(negedge clk);
    cfg_we = 1'b0;
    key_shadow = k;
    key_loads++;
  endtask

  // result side
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected result transfer, got %02h", $realtime, out_ch.out_byte);
        fail_count++;
      end else begin
        if (out_ch.out_byte !== expected_bytes[0]) begin
          $display("%0t: out_byte mismatch, expected %02h got %02h",
                   $realtime, expected_bytes[0], out_ch.out_byte);
          fail_count++;
        end
        void'(expected_bytes.pop_front());
        results_checked++;
      end
    end
  end

  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  initial begin
    #40000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [63:0] k;
    int unsigned msg_len;
    int unsigned mid_at;
    bit long_done;

    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.new_message = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    rst_n = 1'b0;
    no_idle = 1'b0;
    fail_count = 0;
    bytes_sent = 0;
    results_checked = 0;
    msg_count = 0;
    key_loads = 0;
    long_done = 1'b0;
    key_shadow = '0;
    idx_i = 8'd0;
    idx_j = 8'd0;
    for (int i = 0; i < 256; i++) perm_shadow[i] = 8'd0;
    for (int i = 0; i < EKEY_BYTES; i++) ekey_shadow[i] = 8'd0;

    // reset key is zero; first row starts a message before any load
    directed_rows = '{
      '{1'b0, 64'h0000000000000000, 8'h00, 1'b1},
      '{1'b0, 64'h0000000000000000, 8'hFF, 1'b0},
      '{1'b0, 64'h0000000000000000, 8'h00, 1'b0},
      '{1'b0, 64'h0000000000000000, 8'h80, 1'b0},
      '{1'b0, 64'h0000000000000000, 8'h01, 1'b0},
      '{1'b1, 64'hFFFFFFFFFFFFFFFF, 8'h5A, 1'b0},
      '{1'b0, 64'h0000000000000000, 8'hA5, 1'b0},
      '{1'b0, 64'h0000000000000000, 8'h3C, 1'b1},
      '{1'b0, 64'h0000000000000000, 8'hFF, 1'b0},
      '{1'b0, 64'h0000000000000000, 8'h00, 1'b0},
      '{1'b1, 64'h0123456789ABCDEF, 8'hC3, 1'b1},
      '{1'b0, 64'h0000000000000000, 8'h7E, 1'b0},
      '{1'b1, 64'h8000000000000000, 8'h00, 1'b1},
      '{1'b0, 64'h0000000000000000, 8'hFF, 1'b1},
      '{1'b1, 64'h0000000000000001, 8'h55, 1'b1},
      '{1'b0, 64'h0000000000000000, 8'hAA, 1'b0},
      '{1'b1, 64'h00000000FFFFFFFF, 8'h01, 1'b1},
      '{1'b1, 64'hFFFFFFFF00000000, 8'h80, 1'b1},
      '{1'b0, 64'h0000000000000000, 8'hFE, 1'b0},
      '{1'b1, 64'h5DA1C3E00F7B9264, 8'h7F, 1'b1}
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[n]) begin
      if (directed_rows[n].load) load_key(directed_rows[n].key);
      send_byte(directed_rows[n].data, directed_rows[n].start);
    end

    // random messages, first one long enough to wrap both indices
    while (bytes_sent < BYTE_TARGET) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 5))
          0: k = '0;
          1: k = '1;
          default: k = {$urandom, $urandom};
        endcase
        load_key(k);
      end
      msg_len = long_done ? $urandom_range(1, 16) : LONG_MSG_LEN;
      long_done = 1'b1;
      mid_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, msg_len) : 0;
      for (int n = 0; n < msg_len; n++) begin
        if (n != 0 && n == mid_at) load_key({$urandom, $urandom});
        send_byte(8'($urandom_range(0, 255)), n == 0);
      end
    end

    in_ch.valid = 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("sent %0d bytes over %0d messages with %0d key loads, %0d results checked",
             bytes_sent, msg_count, key_loads, results_checked);
    $display("covered key extremes, mid-message key loads and a %0d-byte index wrap",
             LONG_MSG_LEN);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
